@@ rtl/lruct_pkg.sv @@
// Shared types, constants and helper functions for the LRU cache cost tracker.
package lruct_pkg;

  localparam int CAPACITY = 32;
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 64;
  localparam int SIZE_W   = 6;
  localparam int COST_W   = 3;
  localparam int TOTAL_W  = 32;

  localparam logic [COST_W-1:0]  HIT_COST  = 3'd1;
  localparam logic [COST_W-1:0]  MISS_COST = 3'd5;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [OCC_W-1:0]    occ_t;
  typedef logic [CAPACITY-1:0] cell_vec_t;

  // Per-cell control: shift enable and the compare key broadcast to the row.
  typedef struct packed {
    logic shift;
    key_t cmp_key;
  } cell_ctl_t;

  // Fold lower-case ASCII letters to upper case, byte by byte.
  function automatic key_t fold_key(input key_t k);
    key_t r;
    logic [7:0] b;
    r = '0;
    for (int i = 0; i < KEY_W / 8; i++) begin
      b = k[8*i +: 8];
      if (b >= 8'h61 && b <= 8'h7A) begin
        b = b - 8'h20;
      end
      r[8*i +: 8] = b;
    end
    return r;
  endfunction

  // Effective number of entries: the programmed size, clipped to the row length.
  function automatic occ_t eff_size(input logic [SIZE_W-1:0] size);
    occ_t r;
    if (int'(size) > CAPACITY) begin
      r = OCC_W'(CAPACITY);
    end else begin
      r = OCC_W'(size);
    end
    return r;
  endfunction

endpackage

@@ rtl/lruct_cell.sv @@
// One recency cell: holds a key, compares it, and takes its neighbor's key on shift.
module lruct_cell (
  input  logic                  clk_i,
  input  lruct_pkg::cell_ctl_t  ctl_i,
  input  lruct_pkg::key_t       prev_key_i,
  output lruct_pkg::key_t       key_o,
  output logic                  match_o
);

  lruct_pkg::key_t key_q;
  lruct_pkg::key_t key_d;

  always_comb begin
    key_d = ctl_i.shift ? prev_key_i : key_q;
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign match_o = (key_q == ctl_i.cmp_key);

endmodule

@@ rtl/lruct_acc.sv @@
// Saturating running total of access costs.
module lruct_acc (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              add_i,
  input  logic [lruct_pkg::COST_W-1:0]      cost_i,
  output logic [lruct_pkg::TOTAL_W-1:0]     total_o
);

  logic [lruct_pkg::TOTAL_W-1:0] total_q;
  logic [lruct_pkg::TOTAL_W-1:0] total_d;
  logic [lruct_pkg::TOTAL_W-1:0] cost_ext;

  assign cost_ext = lruct_pkg::TOTAL_W'(cost_i);

  always_comb begin
    total_d = total_q;
    if (add_i) begin
      if (total_q > (lruct_pkg::TOTAL_MAX - cost_ext)) begin
        total_d = lruct_pkg::TOTAL_MAX;
      end else begin
        total_d = total_q + cost_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

  assign total_o = total_q;

endmodule

@@ rtl/lru_cache_hit_cost_tracker_unit.sv @@
// Top level of the LRU cache cost tracker: recency cell row, control and result port.
// A key is accepted when start is high and busy is low; its result is registered
// at the end of the update state onto hit_o/access_cost_o/total_cost_o, marked by
// done_o for exactly one cycle. The receiver cannot stall, so a result must be
// captured in the cycle done_o is high. For each key, the accept edge folds the key
// to upper case and registers the parallel compare against every cell of the recency
// row, and the following update cycle shifts the row (busy is high during it). No
// key is taken while busy; a new key can be accepted in the cycle its predecessor's
// result is shown. The cache size register is written through cfg_valid_i/cfg_data_i
// (always ready) and must only change while the block is idle.
module lru_cache_hit_cost_tracker_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lruct_pkg::SIZE_W-1:0]       cfg_data_i,
  // command side
  input  logic                               start,
  output logic                               busy,
  input  logic [lruct_pkg::KEY_W-1:0]        key_i,
  // result side
  output logic                               done_o,
  output logic                               hit_o,
  output logic [lruct_pkg::COST_W-1:0]       access_cost_o,
  output logic [lruct_pkg::TOTAL_W-1:0]      total_cost_o
);

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_e;

  state_e state_q;
  state_e state_d;

  logic [lruct_pkg::SIZE_W-1:0] size_q;
  lruct_pkg::occ_t              occ_q;
  lruct_pkg::occ_t              occ_d;
  lruct_pkg::occ_t              eff;
  lruct_pkg::key_t              fkey;
  lruct_pkg::key_t              key_q;       // folded key of the beat in flight
  lruct_pkg::cell_vec_t         match_q;     // registered compare, valid cells only
  lruct_pkg::cell_vec_t         match;
  lruct_pkg::cell_vec_t         valid;
  lruct_pkg::cell_vec_t         shift;
  lruct_pkg::key_t              cell_key [lruct_pkg::CAPACITY];
  lruct_pkg::key_t              prev_key [lruct_pkg::CAPACITY];
  lruct_pkg::cell_ctl_t         cell_ctl [lruct_pkg::CAPACITY];
  logic                         accept;
  logic                         cache_on;
  logic                         hit_now;
  logic                         upd;
  logic [lruct_pkg::COST_W-1:0] cost_now;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q == ST_UPD);
  assign accept      = start && !busy;
  assign eff         = lruct_pkg::eff_size(size_q);
  assign cache_on    = (eff != '0);
  assign fkey        = lruct_pkg::fold_key(key_i);
  assign upd         = (state_q == ST_UPD);
  assign hit_now     = |match_q;
  assign cost_now    = hit_now ? lruct_pkg::HIT_COST : lruct_pkg::MISS_COST;

  // Cells below the occupancy count hold live entries. Index 0 is most recent.
  always_comb begin
    for (int i = 0; i < lruct_pkg::CAPACITY; i++) begin
      valid[i] = (lruct_pkg::OCC_W'(i) < occ_q);
    end
  end

  // Shift plan: a miss pushes the whole row down by one; a hit shifts only the
  // cells from the front down to the matching one, which is overwritten.
  always_comb begin
    for (int i = 0; i < lruct_pkg::CAPACITY; i++) begin
      shift[i] = upd && cache_on &&
                 (!hit_now || |(match_q & ({lruct_pkg::CAPACITY{1'b1}} << i)));
    end
  end

  // Cell row: compare key comes straight from the folded input at accept time,
  // each cell takes its front neighbor's key on shift, cell 0 takes the new key.
  for (genvar g = 0; g < lruct_pkg::CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_key[g] = key_q;
    end else begin : g_body
      assign prev_key[g] = cell_key[g-1];
    end

    assign cell_ctl[g].shift   = shift[g];
    assign cell_ctl[g].cmp_key = fkey;

    lruct_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (cell_ctl[g]),
      .prev_key_i (prev_key[g]),
      .key_o      (cell_key[g]),
      .match_o    (match[g])
    );
  end

  // Occupancy: hit keeps the count, miss grows it up to the effective size
  // (entries past the new count are evicted simply by falling out of range).
  always_comb begin
    occ_d = occ_q;
    if (upd && cache_on && !hit_now) begin
      occ_d = (occ_q >= eff) ? eff : occ_q + lruct_pkg::OCC_W'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_UPD;
      ST_UPD:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State, control and registered result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      size_q        <= '0;
      occ_q         <= '0;
      done_o        <= 1'b0;
      hit_o         <= 1'b0;
      access_cost_o <= lruct_pkg::MISS_COST;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      done_o  <= upd;
      if (cfg_valid_i && cfg_ready_o) begin
        size_q <= cfg_data_i;
      end
      if (upd) begin
        hit_o         <= hit_now;
        access_cost_o <= cost_now;
      end
    end
  end

  // Payload registers of the beat in flight.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q   <= fkey;
      match_q <= match & valid & {lruct_pkg::CAPACITY{cache_on}};
    end
  end

  lruct_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .add_i   (upd),
    .cost_i  (cost_now),
    .total_o (total_cost_o)
  );

  // The update phase lasts exactly one cycle.
  a_upd_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy) else $error("update phase longer than one cycle");

  // A result is shown only once the row update has finished.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe during update");

  // An accepted key always enters the update phase next.
  a_accept_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted key did not start update");

  // Occupancy never exceeds the row length.
  a_occ_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= lruct_pkg::CAPACITY) else $error("occupancy past capacity");

  // The running total never decreases.
  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> total_cost_o >= $past(total_cost_o)) else $error("total went down");

endmodule
